// ===== hdl/fsand_pkg.sv =====
// Shared types, constants and control structs for the falling sand particle stepper.
// Used by the controller, the datapath and the top level; depends on nothing else.
package fsand_pkg;

  localparam int PARTICLE_COUNT = 1024;
  localparam int COORD_BITS     = 12;
  localparam int IDX_W          = 10;
  localparam int ADDR_W         = $clog2(PARTICLE_COUNT);
  localparam int MEM_W          = 2 * COORD_BITS + 1;
  localparam int CELL_W         = 4;
  localparam int LIMIT_W        = 12;
  localparam int CFG_W          = 12;
  localparam int CFG_IDX_W      = 1;
  localparam int EXT_W          = ((COORD_BITS > LIMIT_W) ? COORD_BITS : LIMIT_W) + 1;
  localparam int MOVE_W         = 2;

  localparam logic [CELL_W-1:0]  CELL_SIZE_RST   = CELL_W'(3);
  localparam logic [LIMIT_W-1:0] FLOOR_LIMIT_RST = LIMIT_W'(170);

  localparam logic signed [EXT_W-1:0] COORD_MAX_E = EXT_W'((64'sd1 <<< (COORD_BITS - 1)) - 1);
  localparam logic signed [EXT_W-1:0] COORD_MIN_E = EXT_W'(-(64'sd1 <<< (COORD_BITS - 1)));

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic [MOVE_W-1:0] MOVE_STAY  = 2'd0;
  localparam logic [MOVE_W-1:0] MOVE_FALL  = 2'd1;
  localparam logic [MOVE_W-1:0] MOVE_RIGHT = 2'd2;
  localparam logic [MOVE_W-1:0] MOVE_LEFT  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_LIMIT = CFG_IDX_W'(1);

  typedef struct packed {
    logic                         op;
    logic [IDX_W-1:0]             particle_index;
    logic signed [COORD_BITS-1:0] load_x;
    logic signed [COORD_BITS-1:0] load_y;
    logic                         coin;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]             out_index;
    logic signed [COORD_BITS-1:0] new_x;
    logic signed [COORD_BITS-1:0] new_y;
    logic [MOVE_W-1:0]            move;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic clr_write;
    logic rd_self;
    logic latch_self;
    logic scan_rd;
    logic cnt_clear;
    logic cnt_inc;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_step;
    logic self_valid;
    logic cnt_last;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/fsand_ctrl.sv =====
// Sequencer for the particle stepper: clearing pass, item dispatch, table scan and finish.
// Depends on fsand_pkg for the command and status structs.
module fsand_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  fsand_pkg::sts_t   sts,
  output fsand_pkg::cmd_t   cmd
);
  import fsand_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_CHK_SELF,
    ST_SCAN,
    ST_SCAN_TAIL,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        cmd.cnt_inc   = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts.is_step) begin
          cmd.rd_self = 1'b1;
          state_nxt   = ST_CHK_SELF;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_CHK_SELF: begin
        cmd.latch_self = 1'b1;
        cmd.cnt_clear  = 1'b1;
        state_nxt      = sts.self_valid ? ST_SCAN : ST_FINISH;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = ST_SCAN_TAIL;
        end
      end
      ST_SCAN_TAIL: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/fsand_dp.sv =====
// Datapath of the particle stepper: configuration registers, position table memory,
// neighbor scan flags, move decision and output register. Depends on fsand_pkg.
module fsand_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fsand_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fsand_pkg::CFG_W-1:0]    cfg_wdata,
  input  fsand_pkg::in_item_t            in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output fsand_pkg::out_item_t           out_data,
  input  fsand_pkg::cmd_t                cmd,
  output fsand_pkg::sts_t                sts
);
  import fsand_pkg::*;

  logic [CELL_W-1:0]         cell_size_r;
  logic signed [LIMIT_W-1:0] floor_limit_r;
  in_item_t                  item_r;
  logic [ADDR_W-1:0]         cnt_r;
  logic [MEM_W-1:0]          mem [PARTICLE_COUNT];
  logic [MEM_W-1:0]          rd_data_r;
  logic                      scan_chk_r;
  logic signed [COORD_BITS-1:0] self_x_r, self_y_r;
  logic                      self_ok_r;
  logic                      below_r, right_r, left_r;
  logic                      below_nxt, right_nxt, left_nxt;
  logic                      out_valid_r;
  out_item_t                 out_data_r, out_data_nxt;

  logic [IDX_W+ADDR_W-1:0]   idx_wide;
  logic [ADDR_W-1:0]         idx_addr;
  logic                      in_range;
  logic                      rd_valid;
  logic signed [COORD_BITS-1:0] rd_x, rd_y;
  logic signed [EXT_W-1:0]   rd_x_e, rd_y_e, self_x_e, self_y_e, step_e, lim_e;
  logic signed [EXT_W-1:0]   tgt_b, tgt_r, tgt_l;
  logic                      can_b, can_r, can_l;
  logic signed [COORD_BITS-1:0] step_x, step_y;
  logic [MOVE_W-1:0]         step_mv;
  logic                      mem_we;
  logic [ADDR_W-1:0]         mem_waddr, mem_raddr;
  logic [MEM_W-1:0]          mem_wdata;

  assign idx_wide = (IDX_W + ADDR_W)'(item_r.particle_index);
  assign idx_addr = idx_wide[ADDR_W-1:0];
  assign in_range = (32'(item_r.particle_index) < PARTICLE_COUNT);

  assign rd_valid = rd_data_r[MEM_W-1];
  assign rd_x     = rd_data_r[2*COORD_BITS-1:COORD_BITS];
  assign rd_y     = rd_data_r[COORD_BITS-1:0];
  assign rd_x_e   = EXT_W'(rd_x);
  assign rd_y_e   = EXT_W'(rd_y);
  assign self_x_e = EXT_W'(self_x_r);
  assign self_y_e = EXT_W'(self_y_r);
  assign step_e   = EXT_W'(cell_size_r);
  assign lim_e    = EXT_W'(floor_limit_r);
  assign tgt_b    = self_y_e + step_e;
  assign tgt_r    = self_x_e + step_e;
  assign tgt_l    = self_x_e - step_e;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r   <= CELL_SIZE_RST;
      floor_limit_r <= FLOOR_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CELL_SIZE:   cell_size_r   <= cfg_wdata[CELL_W-1:0];
        CFG_FLOOR_LIMIT: floor_limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      scan_chk_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cnt_clear) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + ADDR_W'(1);
      end
      scan_chk_r <= cmd.scan_rd;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign mem_we    = cmd.clr_write
                   | (cmd.finish & in_range & ((item_r.op == OP_LOAD) | self_ok_r));
  assign mem_waddr = cmd.clr_write ? cnt_r : idx_addr;
  assign mem_raddr = cmd.rd_self ? idx_addr : cnt_r;

  always_comb begin
    if (cmd.clr_write) begin
      mem_wdata = '0;
    end else if (item_r.op == OP_LOAD) begin
      mem_wdata = {1'b1, item_r.load_x, item_r.load_y};
    end else begin
      mem_wdata = {1'b1, step_x, step_y};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_comb begin
    below_nxt = below_r;
    right_nxt = right_r;
    left_nxt  = left_r;
    if (scan_chk_r && rd_valid) begin
      if (rd_y_e == tgt_b && rd_x_e == self_x_e) begin
        below_nxt = 1'b0;
      end else if (rd_x_e == tgt_r && rd_y_e == self_y_e) begin
        right_nxt = 1'b0;
      end else if (rd_x_e == tgt_l && rd_y_e == self_y_e) begin
        left_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= in_data;
    end
    if (cmd.latch_self) begin
      self_x_r  <= rd_x;
      self_y_r  <= rd_y;
      self_ok_r <= rd_valid;
      below_r   <= 1'b1;
      right_r   <= 1'b1;
      left_r    <= 1'b1;
    end else begin
      below_r <= below_nxt;
      right_r <= right_nxt;
      left_r  <= left_nxt;
    end
    if (cmd.finish) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign can_b = below_r && (tgt_b <= COORD_MAX_E) && (self_y_e <= lim_e);
  assign can_r = right_r && (tgt_r <= COORD_MAX_E) && !item_r.coin;
  assign can_l = left_r && (tgt_l >= COORD_MIN_E) && item_r.coin;

  always_comb begin
    step_x  = self_x_r;
    step_y  = self_y_r;
    step_mv = MOVE_STAY;
    if (can_b) begin
      step_y  = tgt_b[COORD_BITS-1:0];
      step_mv = MOVE_FALL;
    end else if (can_r) begin
      step_x  = tgt_r[COORD_BITS-1:0];
      step_mv = MOVE_RIGHT;
    end else if (can_l) begin
      step_x  = tgt_l[COORD_BITS-1:0];
      step_mv = MOVE_LEFT;
    end
  end

  always_comb begin
    out_data_nxt           = '0;
    out_data_nxt.out_index = item_r.particle_index;
    if (in_range) begin
      if (item_r.op == OP_LOAD) begin
        out_data_nxt.new_x = item_r.load_x;
        out_data_nxt.new_y = item_r.load_y;
      end else if (self_ok_r) begin
        out_data_nxt.new_x = step_x;
        out_data_nxt.new_y = step_y;
        out_data_nxt.move  = step_mv;
      end
    end
  end

  assign sts.is_step    = (item_r.op == OP_STEP) && in_range;
  assign sts.self_valid = rd_valid;
  assign sts.cnt_last   = (cnt_r == ADDR_W'(PARTICLE_COUNT - 1));
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/falling_sand_particle_step_core.sv =====
// Top level of the falling sand particle stepper: joins the sequencer and the datapath.
// Depends on fsand_pkg, fsand_ctrl and fsand_dp.
//
//   Port group   Direction  Transfer condition            Payload
//   in_*         input      in_valid && !in_stall         in_item_t
//   out_*        output     out_valid && !out_stall       out_item_t
//   cfg_*        input      cfg_we                        cfg_index, cfg_wdata
//
// A load passes from dispatch straight to finish; a step first reads its own entry and, if it is valid,
// scans the table, reading one table entry per cycle through the single read port of the table.
// After reset a clearing pass writes every table entry empty, with in_stall high.
// A finished result waits in the output register while the next item is accepted;
// the block holds in its finish state only when that register is still full and stalled.
module falling_sand_particle_step_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  fsand_pkg::in_item_t             in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output fsand_pkg::out_item_t            out_data,
  input  logic                            cfg_we,
  input  logic [fsand_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fsand_pkg::CFG_W-1:0]     cfg_wdata
);
  import fsand_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fsand_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fsand_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
